/* hdl/sli_pkg.sv */
`default_nettype none

package sli_pkg;

  localparam int CAPACITY  = 16;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 3;
  localparam int OUT_CNT_W = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_DEL_RD,
    S_DEL_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } wr_req_t;

endpackage

`default_nettype wire

/* hdl/sli_store.sv */
`default_nettype none

module sli_store
  import sli_pkg::*;
(
  input  wire logic                     clk,
  input  wire wr_req_t                  wr,
  input  wire logic [IDX_W-1:0]         rd_addr,
  output logic signed [DATA_W-1:0]      rd_data,
  output logic signed [DATA_W-1:0]      head
);

  logic [DATA_W-1:0] mem [CAPACITY];

  // The head register mirrors entry zero so the smallest value needs no read.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
      if (wr.addr == '0) begin
        head <= $signed(wr.data);
      end
    end
    rd_data <= $signed(mem[rd_addr]);
  end

endmodule

`default_nettype wire

/* hdl/sorted_list_insert_delete.sv */
// Sorted list of up to CAPACITY signed 32-bit values, kept in ascending order.
// A command transaction is accepted at a rising edge where start is high and
// busy is low; opcode selects insert or delete and value carries the operand.
// Busy stays high until the result has been shown. Exactly one result follows
// each command: status, entry_count and smallest_value are valid for the one
// cycle in which done is high, and busy falls after that cycle.
// Insert walks the list from its tail, moving each larger entry up by one
// slot; delete walks from the head, finds the first equal entry and moves the
// rest down. Each visited entry passes through the single read port of the
// entry store and a comparison against the key; a full list or an empty
// delete goes straight from idle to the result state. The next command can
// be taken once busy has fallen.
// Reset empties the list; the entry store itself is not swept because no
// value read from a slot beyond the count is ever used. The receiver cannot
// stall results.
`default_nettype none

module sorted_list_insert_delete
  import sli_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       opcode,
  input  wire logic signed [DATA_W-1:0]   value,
  output logic                            done,
  output logic [STATUS_W-1:0]             status,
  output logic [OUT_CNT_W-1:0]            entry_count,
  output logic signed [DATA_W-1:0]        smallest_value
);

  state_t                     state, state_next;
  logic [CNT_W-1:0]           idx, idx_next;
  logic [CNT_W-1:0]           count, count_next;
  logic                       found, found_next;
  status_t                    stat, stat_next;
  logic signed [DATA_W-1:0]   key;
  wr_req_t                    wr;
  logic [IDX_W-1:0]           rd_addr;
  logic signed [DATA_W-1:0]   rd_data;
  logic signed [DATA_W-1:0]   head;
  logic [CNT_W-1:0]           idx_m1;
  logic [CNT_W-1:0]           count_m1;
  logic                       accept;
  logic                       gt;
  logic                       eq;

  sli_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .head    (head)
  );

  assign accept   = start && !busy;
  assign idx_m1   = idx - CNT_W'(1);
  assign count_m1 = count - CNT_W'(1);
  assign gt       = rd_data > key;
  assign eq       = rd_data == key;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (opcode == OP_INSERT) begin
            state_next = (count == CNT_W'(CAPACITY)) ? S_DONE : S_INS_RD;
          end else begin
            state_next = (count == '0) ? S_DONE : S_DEL_RD;
          end
        end
      end
      S_INS_RD:  state_next = (idx == '0) ? S_DONE : S_INS_CMP;
      S_INS_CMP: state_next = gt ? S_INS_RD : S_DONE;
      S_DEL_RD:  state_next = (idx == count) ? S_DONE : S_DEL_CMP;
      S_DEL_CMP: state_next = S_DEL_RD;
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    idx_next   = idx;
    count_next = count;
    found_next = found;
    stat_next  = stat;
    wr         = '0;
    rd_addr    = idx_m1[IDX_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (opcode == OP_INSERT) begin
            idx_next  = count;
            stat_next = ST_FULL;
          end else begin
            idx_next   = '0;
            found_next = 1'b0;
            stat_next  = ST_EMPTY;
          end
        end
      end
      S_INS_RD: begin
        if (idx == '0) begin
          wr.en      = 1'b1;
          wr.addr    = '0;
          wr.data    = key;
          count_next = count + CNT_W'(1);
          stat_next  = ST_INSERTED;
        end
      end
      S_INS_CMP: begin
        wr.en   = 1'b1;
        wr.addr = idx[IDX_W-1:0];
        if (gt) begin
          wr.data  = rd_data;
          idx_next = idx_m1;
        end else begin
          wr.data    = key;
          count_next = count + CNT_W'(1);
          stat_next  = ST_INSERTED;
        end
      end
      S_DEL_RD: begin
        rd_addr = idx[IDX_W-1:0];
        if (idx == count) begin
          if (found) begin
            wr.en      = 1'b1;
            wr.addr    = count_m1[IDX_W-1:0];
            wr.data    = '0;
            count_next = count_m1;
            stat_next  = ST_DELETED;
          end else begin
            stat_next = ST_NOT_FOUND;
          end
        end
      end
      S_DEL_CMP: begin
        if (found) begin
          wr.en   = 1'b1;
          wr.addr = idx_m1[IDX_W-1:0];
          wr.data = rd_data;
        end else if (eq) begin
          found_next = 1'b1;
        end
        idx_next = idx + CNT_W'(1);
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      found <= 1'b0;
      idx   <= '0;
      stat  <= ST_INSERTED;
    end else begin
      state <= state_next;
      count <= count_next;
      found <= found_next;
      idx   <= idx_next;
      stat  <= stat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key <= value;
    end
  end

  assign busy           = state != S_IDLE;
  assign done           = state == S_DONE;
  assign status         = stat;
  assign entry_count    = OUT_CNT_W'(count);
  assign smallest_value = (count != '0) ? head : '0;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result shown while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire

/* test/sorted_list_insert_delete_test.sv */
`default_nettype none

module sorted_list_insert_delete_test
  import sli_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t                  status;
    logic [OUT_CNT_W-1:0]     count;
    logic signed [DATA_W-1:0] smallest;
  } list_outcome_t;

  class sorted_list_scoreboard;
    logic signed [DATA_W-1:0] list_entries [CAPACITY];
    int                       list_fill;
    list_outcome_t            expected_outcomes [$];
    int                       mismatches;
    int                       status_hits [5];
    int                       peak_fill;

    function new();
      foreach (list_entries[i]) list_entries[i] = '0;
      list_fill  = 0;
      mismatches = 0;
      peak_fill  = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function int pending();
      return expected_outcomes.size();
    endfunction

    // Applies an accepted command to the shadow list and queues its outcome.
    function void note_command(logic op, logic signed [DATA_W-1:0] val);
      list_outcome_t outcome;
      int pos;
      int i;
      pos = 0;
      if (op == OP_INSERT) begin
        if (list_fill >= CAPACITY) begin
          outcome.status = ST_FULL;
        end else begin
          while (pos < list_fill && list_entries[pos] <= val) pos++;
          for (i = list_fill; i > pos; i--) list_entries[i] = list_entries[i-1];
          list_entries[pos] = val;
          list_fill++;
          outcome.status = ST_INSERTED;
        end
      end else begin
        if (list_fill == 0) begin
          outcome.status = ST_EMPTY;
        end else begin
          while (pos < list_fill && list_entries[pos] != val) pos++;
          if (pos >= list_fill) begin
            outcome.status = ST_NOT_FOUND;
          end else begin
            for (i = pos; i + 1 < list_fill; i++) list_entries[i] = list_entries[i+1];
            list_fill--;
            list_entries[list_fill] = '0;
            outcome.status = ST_DELETED;
          end
        end
      end
      if (list_fill > peak_fill) peak_fill = list_fill;
      outcome.count    = OUT_CNT_W'(list_fill);
      outcome.smallest = (list_fill > 0) ? list_entries[0] : '0;
      expected_outcomes.push_back(outcome);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic [STATUS_W-1:0] st, logic [OUT_CNT_W-1:0] cnt,
                      logic signed [DATA_W-1:0] sm);
      list_outcome_t outcome;
      if (st < 5) status_hits[st]++;
      if (expected_outcomes.size() == 0) begin
        report_mismatch("result arrived with no command outstanding");
      end else begin
        outcome = expected_outcomes.pop_front();
        if (st !== outcome.status)
          report_mismatch($sformatf("status %0d, expected %0d", st, outcome.status));
        if (cnt !== outcome.count)
          report_mismatch($sformatf("entry_count %0d, expected %0d", cnt, outcome.count));
        if (sm !== outcome.smallest)
          report_mismatch($sformatf("smallest_value %0d, expected %0d", sm, outcome.smallest));
      end
    endtask
  endclass

  localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] MOST_POSITIVE = 32'sh7fff_ffff;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic                       opcode;
  logic signed [DATA_W-1:0]   value;
  logic                       done;
  logic [STATUS_W-1:0]        status;
  logic [OUT_CNT_W-1:0]       entry_count;
  logic signed [DATA_W-1:0]   smallest_value;

  sorted_list_scoreboard sb = new();
  int commands_accepted = 0;
  int sender_idle_pct = 0;

  sorted_list_insert_delete dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .value(value),
    .done(done),
    .status(status),
    .entry_count(entry_count),
    .smallest_value(smallest_value)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(status, entry_count, smallest_value);
      if (start && !busy) begin
        sb.note_command(opcode, value);
        commands_accepted++;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue_command(logic op, logic signed [DATA_W-1:0] val);
    int taken;
    if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    start  = 1'b1;
    opcode = op;
    value  = val;
    taken  = commands_accepted;
    do @(negedge clk); while (commands_accepted == taken);
  endtask

  task automatic wait_for_results();
    start = 1'b0;
    while (sb.pending() > 0) @(negedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] val;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: val = $signed($urandom_range(0, 20)) - 10;
      4, 5, 6:    val = $urandom;
      7:          val = $urandom_range(0, 1) ? MOST_NEGATIVE : MOST_POSITIVE;
      8:          val = $urandom_range(0, 1) ? MOST_NEGATIVE + $urandom_range(0, 3)
                                             : MOST_POSITIVE - $urandom_range(0, 3);
      default:    val = (sb.list_fill > 0) ? sb.list_entries[$urandom_range(0, sb.list_fill - 1)]
                                           : $urandom;
    endcase
    return val;
  endfunction

  task automatic run_phase(int n_items, int idle_pct);
    int insert_pct;
    logic op;
    logic signed [DATA_W-1:0] val;
    sender_idle_pct = idle_pct;
    insert_pct = 50;
    for (int k = 0; k < n_items; k++) begin
      if (k % 20 == 0) insert_pct = $urandom_range(0, 1) ? 80 : 25;
      op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_DELETE;
      if (op == OP_DELETE && sb.list_fill > 0 && $urandom_range(0, 99) < 70)
        val = sb.list_entries[$urandom_range(0, sb.list_fill - 1)];
      else
        val = pick_value();
      issue_command(op, val);
    end
    wait_for_results();
  endtask

  initial begin
    rst    = 1'b1;
    start  = 1'b0;
    opcode = OP_INSERT;
    value  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    issue_command(OP_DELETE, 32'sd7);
    issue_command(OP_INSERT, MOST_NEGATIVE);
    issue_command(OP_INSERT, MOST_POSITIVE);
    issue_command(OP_INSERT, 32'sd0);
    issue_command(OP_INSERT, -32'sd1);
    issue_command(OP_INSERT, 32'sd1);
    issue_command(OP_INSERT, 32'sd0);
    issue_command(OP_DELETE, 32'sd5);
    issue_command(OP_DELETE, 32'sd0);
    issue_command(OP_DELETE, MOST_POSITIVE);
    issue_command(OP_DELETE, MOST_NEGATIVE);
    for (int k = 0; k < 13; k++)
      issue_command(OP_INSERT, (k % 2) ? MOST_POSITIVE - k : MOST_NEGATIVE + k * 1000);
    issue_command(OP_INSERT, 32'sd3);
    wait_for_results();

    run_phase(210, 29);
    run_phase(210, 68);
    run_phase(210, 0);

    repeat (60) @(negedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
    $display("Ran %0d commands: %0d inserted, %0d deleted, %0d not found, %0d empty, %0d full.",
             commands_accepted, sb.status_hits[ST_INSERTED], sb.status_hits[ST_DELETED],
             sb.status_hits[ST_NOT_FOUND], sb.status_hits[ST_EMPTY], sb.status_hits[ST_FULL]);
    $display("The list reached a peak fill of %0d entries.", sb.peak_fill);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding.", sb.pending());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

/* sorted_list_insert_delete.f */
hdl/sli_pkg.sv
hdl/sli_store.sv
hdl/sorted_list_insert_delete.sv
test/sorted_list_insert_delete_test.sv
